FILE: hdl/extended_gcd_modular_inverse_unit_defines.svh
// Assertion macros shared by the extended gcd / modular inverse unit.
// No dependencies.
`ifndef EXTENDED_GCD_MODULAR_INVERSE_UNIT_DEFINES_SVH
`define EXTENDED_GCD_MODULAR_INVERSE_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define EGI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define EGI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/egi_pkg.sv
// Package for the extended gcd / modular inverse unit: constants, types.
// No dependencies.
package egi_pkg;
   localparam int unsigned WIDTH_DEFAULT = 32;
   localparam int unsigned FIELD_W = 32;
   localparam int unsigned COEF_W  = 33;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_UPD_U,
      ST_UPD_V,
      ST_RED,
      ST_DONE
   } state_type;

   // divider control between sequencer and divider
   typedef struct packed {
      logic start;
   } div_ctl_type;
endpackage

FILE: hdl/egi_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on egi_pkg.
`include "extended_gcd_modular_inverse_unit_defines.svh"
module egi_divider #(
   parameter int unsigned W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  egi_pkg::div_ctl_type ctl,
   input  logic [W-1:0]        dividend,
   input  logic [W-1:0]        divisor,
   output logic                done,
   output logic [W-1:0]        quotient,
   output logic [W-1:0]        remainder
);
   import egi_pkg::*;
   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[W-1]};
      diff    = trial - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `EGI_ASSERT_IMP(a_done_not_busy, clock, reset, done_ff, !busy_ff, "divider done while busy")
   `EGI_ASSERT_NEXT(a_start_busy, clock, reset, ctl.start, busy_ff, "divider did not start")
   `EGI_ASSERT_IMP(a_cnt_range, clock, reset, busy_ff, cnt_ff != '0, "divider count ran out")
endmodule

FILE: hdl/extended_gcd_modular_inverse_unit.sv
// Top level of the extended gcd / modular inverse unit: sequencer and state.
// Depends on egi_pkg, egi_divider and the defines header.
//
// Usage: drive req_value and req_modulus and pulse start while busy is low;
// the request is taken on that edge and busy rises at once. The unit runs
// the extended Euclidean algorithm, one round per quotient, using a single
// shared bit-serial divider. Each round launches a division in ST_CHECK,
// waits for it in ST_DIV, then updates in ST_UPD_U and ST_UPD_V; the inverse
// reduction takes one more division. One request at a time: no new request
// is taken until busy falls. The result appears on the rsp_ ports for one
// cycle with rsp_valid high; the receiver cannot stall and must take it then.
// busy falls in the same cycle. Synchronous reset returns the sequencer to
// idle and drops any request in flight; no state is kept between requests.
`include "extended_gcd_modular_inverse_unit_defines.svh"
module extended_gcd_modular_inverse_unit #(
   parameter int unsigned WIDTH = egi_pkg::WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [egi_pkg::FIELD_W-1:0] req_value,
   input  logic [egi_pkg::FIELD_W-1:0] req_modulus,
   output logic                        rsp_valid,
   output logic [egi_pkg::FIELD_W-1:0] rsp_gcd,
   output logic signed [egi_pkg::COEF_W-1:0] rsp_bezout_x,
   output logic signed [egi_pkg::COEF_W-1:0] rsp_bezout_y,
   output logic [egi_pkg::FIELD_W-1:0] rsp_inverse,
   output logic                        rsp_inverse_exists
);
   import egi_pkg::*;
   localparam int unsigned CO_W = WIDTH + 1;
   localparam int unsigned IN_W = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;

   state_type state_ff, state_in;
   logic [WIDTH-1:0] r0_ff, r0_in, r1_ff, r1_in, m_ff, m_in, q_ff, q_in;
   logic [CO_W-1:0]  u0_ff, u0_in, u1_ff, u1_in, v0_ff, v0_in, v1_ff, v1_in;
   logic [WIDTH-1:0] inv_ff, inv_in;
   logic             valid_ff, valid_in;

   div_ctl_type      dctl;
   logic             ddone;
   logic [WIDTH-1:0] dquo, drem, dnd, dsr;
   logic [CO_W-1:0]  prod, mag;
   logic             exists;

   egi_divider #(.W(WIDTH)) u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .dividend(dnd), .divisor(dsr),
      .done(ddone), .quotient(dquo), .remainder(drem)
   );

   // coefficients fit in WIDTH+1 bits, so a truncated product suffices
   assign prod   = CO_W'(q_ff) * (state_ff == ST_UPD_U ? u1_ff : v1_ff);
   assign exists = (r0_ff == WIDTH'(1)) && (m_ff != '0);
   assign mag    = u0_ff[CO_W-1] ? (~u0_ff + 1'b1) : u0_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_CHECK;
         ST_CHECK: state_in = (r1_ff == '0) ? (exists ? ST_RED : ST_DONE) : ST_DIV;
         ST_DIV:   if (ddone) state_in = ST_UPD_U;
         ST_UPD_U: state_in = ST_UPD_V;
         ST_UPD_V: state_in = ST_CHECK;
         ST_RED:   if (ddone) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // divider launch and operands
   always_comb begin
      dctl.start = 1'b0;
      dnd = r0_ff;
      dsr = r1_ff;
      if (state_ff == ST_CHECK) begin
         if (r1_ff != '0) begin
            dctl.start = 1'b1;
         end else if (exists) begin
            dctl.start = 1'b1;
            dnd = mag[WIDTH-1:0];
            dsr = m_ff;
         end
      end
   end

   // datapath
   always_comb begin
      r0_in = r0_ff; r1_in = r1_ff; m_in = m_ff; q_in = q_ff;
      u0_in = u0_ff; u1_in = u1_ff; v0_in = v0_ff; v1_in = v1_ff;
      inv_in = inv_ff;
      valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               r0_in = WIDTH'(req_value[IN_W-1:0]);
               r1_in = WIDTH'(req_modulus[IN_W-1:0]);
               m_in  = WIDTH'(req_modulus[IN_W-1:0]);
               u0_in = CO_W'(1); u1_in = '0;
               v0_in = '0;       v1_in = CO_W'(1);
               inv_in = '0;
            end
         end
         ST_DIV: begin
            if (ddone) begin
               q_in  = dquo;
               r0_in = r1_ff;
               r1_in = drem;
            end
         end
         ST_UPD_U: begin
            u0_in = u1_ff;
            u1_in = u0_ff - prod;
         end
         ST_UPD_V: begin
            v0_in = v1_ff;
            v1_in = v0_ff - prod;
         end
         ST_RED: begin
            if (ddone) begin
               if (u0_ff[CO_W-1] && drem != '0) inv_in = m_ff - drem;
               else if (u0_ff[CO_W-1])         inv_in = '0;
               else                             inv_in = drem;
            end
         end
         ST_DONE: valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      r0_ff <= r0_in; r1_ff <= r1_in; m_ff <= m_in; q_ff <= q_in;
      u0_ff <= u0_in; u1_ff <= u1_in; v0_ff <= v0_in; v1_ff <= v1_in;
      inv_ff <= inv_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = valid_ff;
   assign rsp_gcd            = FIELD_W'({{(FIELD_W+1){1'b0}}, r0_ff});
   assign rsp_bezout_x       = COEF_W'({{COEF_W{u0_ff[CO_W-1]}}, u0_ff});
   assign rsp_bezout_y       = COEF_W'({{COEF_W{v0_ff[CO_W-1]}}, v0_ff});
   assign rsp_inverse        = exists ? FIELD_W'({{(FIELD_W+1){1'b0}}, inv_ff}) : '0;
   assign rsp_inverse_exists = exists;

   `EGI_ASSERT_IMP(a_valid_idle, clock, reset, rsp_valid, state_ff == ST_IDLE, "result outside idle")
   `EGI_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "request not taken")
   `EGI_ASSERT_IMP(a_div_only_wait, clock, reset, ddone, state_ff == ST_DIV || state_ff == ST_RED, "stray divider done")
endmodule

FILE: dv/testbench.sv
// Self-checking bench for the extended gcd / modular inverse unit.
// Depends on egi_pkg and extended_gcd_modular_inverse_unit; holds its own Euclid predictor.
`timescale 1ns / 100ps
module testbench;
   import egi_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 4000000;

   typedef struct packed {
      logic [FIELD_W-1:0] gcd;
      logic [COEF_W-1:0]  bezout_x;
      logic [COEF_W-1:0]  bezout_y;
      logic [FIELD_W-1:0] inverse;
      logic               inverse_exists;
   } euclid_result_type;

   class euclid_scoreboard;
      euclid_result_type pending[$];
      int unsigned    errors = 0;

      function euclid_result_type solve_euclid(logic [31:0] value, logic [31:0] modulus);
         logic [63:0] r0, r1, r2, u0, u1, u2, v0, v1, v2, q, mag, rem;
         euclid_result_type res;
         r0 = {32'd0, value};
         r1 = {32'd0, modulus};
         u0 = 64'd1; u1 = 64'd0;
         v0 = 64'd0; v1 = 64'd1;
         while (r1 != 64'd0) begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            u2 = u0 - q * u1;
            v2 = v0 - q * v1;
            r0 = r1; r1 = r2;
            u0 = u1; u1 = u2;
            v0 = v1; v1 = v2;
         end
         res.gcd            = r0[31:0];
         res.bezout_x       = u0[32:0];
         res.bezout_y       = v0[32:0];
         res.inverse_exists = (r0 == 64'd1) && (modulus != 32'd0);
         res.inverse        = '0;
         if (res.inverse_exists) begin
            if (u0[63]) begin
               mag = ~u0 + 64'd1;
               rem = mag % r1_mod(modulus);
               res.inverse = (rem == 64'd0) ? 32'd0 : 32'({32'd0, modulus} - rem);
            end else begin
               res.inverse = 32'(u0 % r1_mod(modulus));
            end
         end
         return res;
      endfunction

      function logic [63:0] r1_mod(logic [31:0] modulus);
         return {32'd0, modulus};
      endfunction

      function void note_request(logic [31:0] value, logic [31:0] modulus);
         pending = {pending, solve_euclid(value, modulus)};
      endfunction

      function void check_response(euclid_result_type got);
         euclid_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: response with nothing outstanding: %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch gcd exp %h got %h | x exp %h got %h | y exp %h got %h",
                     $time, want.gcd, got.gcd, want.bezout_x, got.bezout_x,
                     want.bezout_y, got.bezout_y);
            $display("%0t:          inverse exp %h got %h | exists exp %b got %b",
                     $time, want.inverse, got.inverse, want.inverse_exists,
                     got.inverse_exists);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset, start, busy;
   logic [FIELD_W-1:0] req_value, req_modulus;
   logic rsp_valid, rsp_inverse_exists;
   logic [FIELD_W-1:0] rsp_gcd, rsp_inverse;
   logic signed [COEF_W-1:0] rsp_bezout_x, rsp_bezout_y;

   euclid_scoreboard sb = new();
   int unsigned cycles = 0;
   int unsigned idle_pct = 0;

   extended_gcd_modular_inverse_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_value(req_value), .req_modulus(req_modulus),
      .rsp_valid(rsp_valid), .rsp_gcd(rsp_gcd),
      .rsp_bezout_x(rsp_bezout_x), .rsp_bezout_y(rsp_bezout_y),
      .rsp_inverse(rsp_inverse), .rsp_inverse_exists(rsp_inverse_exists)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response({rsp_gcd, rsp_bezout_x, rsp_bezout_y, rsp_inverse,
                            rsp_inverse_exists});
   end

   // hold start until taken; then maybe idle before the next request
   task automatic send_request(logic [31:0] value, logic [31:0] modulus);
      int unsigned gap;
      req_value   <= value;
      req_modulus <= modulus;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(value, modulus);
      gap = 0;
      if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 20);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(3))
         0: return $urandom_range(255);
         1: return $urandom & ((32'd1 << $urandom_range(31)) - 1);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] a, m, g;
      start = 1'b0;
      reset = 1'b1;
      req_value = '0;
      req_modulus = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: zero operands, modulus one, extremes, worst-case Fibonacci pair
      send_request(32'd0, 32'd0);
      send_request(32'd0, 32'd5);
      send_request(32'd7, 32'd0);
      send_request(32'hFFFF_FFFF, 32'd0);
      send_request(32'd5, 32'd1);
      send_request(32'hFFFF_FFFF, 32'd1);
      send_request(32'd0, 32'd1);
      send_request(32'd1, 32'hFFFF_FFFF);
      send_request(32'd0, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_request(32'h8000_0000, 32'hFFFF_FFFF);
      send_request(32'd3, 32'd7);
      send_request(32'd6, 32'd9);
      send_request(32'd2, 32'd4);
      send_request(32'd17, 32'd3120);
      send_request(32'd3120, 32'd17);
      send_request(32'd2971215073, 32'd1836311903);
      send_request(32'd1836311903, 32'd2971215073);
      send_request(32'd1, 32'd1);

      for (int i = 0; i < 400; i++) begin
         case (i / 100)
            0: idle_pct = 0;
            1: idle_pct = 71;
            2: idle_pct = 0;
            default: idle_pct = 13;
         endcase
         a = rand_operand();
         m = rand_operand();
         case ($urandom_range(9))
            0: m = $urandom_range(1);
            1: a = 32'd0;
            2: begin
               // shared factor, so no inverse
               g = $urandom_range(2, 1000);
               a = g * $urandom_range(4000000);
               m = g * $urandom_range(1, 4000000);
            end
            default: ;
         endcase
         send_request(a, m);
      end
      start <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end
endmodule
